### design/delayed_match_window_tracker_macros.svh
// assertion macros for the window tracker datapath
`ifndef DELAYED_MATCH_WINDOW_TRACKER_MACROS_SVH
`define DELAYED_MATCH_WINDOW_TRACKER_MACROS_SVH

// condition holds at every edge out of reset
`define DMWT_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define DMWT_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define DMWT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/dmwt_pkg.sv
// shared types, constants and helpers for the delayed match window tracker
package dmwt_pkg;

    localparam int DEF_TABLE_DEPTH = 32;
    localparam int DEF_TIME_BITS   = 48;

    localparam int OP_W       = 2;
    localparam int CAM_W      = 3;
    localparam int BODY_W     = 3;
    localparam int BC_W       = 4;
    localparam int DELAY_W    = 24;
    localparam int CNT_W      = 32;
    localparam int NARROW_W   = 6;
    localparam int CFG_ADDR_W = 2;

    localparam int IN_USER_W  = OP_W + 1;
    // pending, kept, removed, matched, expired, dropped, padded to bytes
    localparam int OUT_FIELDS_W = NARROW_W + CNT_W + CNT_W + 1 + NARROW_W + 1;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    // operation codes
    localparam logic [OP_W-1:0] OP_FRONT = 2'd0;
    localparam logic [OP_W-1:0] OP_REAR  = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK  = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_DELAY  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_DELAY  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_BODY_LIMIT = 2'd2;

    localparam logic [DELAY_W-1:0] RST_MIN_DELAY  = 24'd500;
    localparam logic [DELAY_W-1:0] RST_MAX_DELAY  = 24'd3000;
    localparam logic [BC_W-1:0]    RST_BODY_LIMIT = 4'd6;

    localparam logic [CAM_W-1:0]  FRONT_CAM_LIMIT = 3'd5;
    localparam logic [CAM_W-1:0]  REAR_LEFT_CAM   = 3'd5;
    localparam logic [CAM_W-1:0]  REAR_RIGHT_CAM  = 3'd6;
    localparam logic [BODY_W-1:0] ZONE_SPLIT      = 3'd3;

    typedef struct packed {
        logic load;
        logic apply;
        logic scan_init;
        logic scan_step;
        logic scan_end;
        logic publish;
    } t_cmd;

    typedef struct packed {
        logic need_scan;
        logic scan_done;
        logic out_free;
    } t_status;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
    endfunction

endpackage

### design/dmwt_ram.sv
// generic single-write, single-read ram with registered read data
module dmwt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/dmwt_ctrl.sv
// sequencing state machine for the window tracker
module dmwt_ctrl import dmwt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_status.need_scan) begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_SCAN;
                end else begin
                    o_cmd.apply = 1'b1;
                    n_state     = S_DONE;
                end
            end
            S_SCAN: begin
                if (i_status.scan_done) begin
                    o_cmd.scan_end = 1'b1;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### design/dmwt_datapath.sv
// table, counters, config registers and result register of the window tracker
`include "delayed_match_window_tracker_macros.svh"

module dmwt_datapath import dmwt_pkg::*; #(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int TIME_BITS   = DEF_TIME_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [DELAY_W-1:0]    i_cfg_wdata,
    input  logic [OP_W-1:0]       i_operation,
    input  logic                  i_frame_valid,
    input  logic [CAM_W-1:0]      i_camera,
    input  logic [BODY_W-1:0]     i_body,
    input  logic [TIME_BITS-1:0]  i_time_ms,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [NARROW_W-1:0]   o_pending_count,
    output logic [CNT_W-1:0]      o_kept_total,
    output logic [CNT_W-1:0]      o_removed_total,
    output logic                  o_matched,
    output logic [NARROW_W-1:0]   o_expired_now,
    output logic                  o_dropped
);

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int FILL_W = $clog2(TABLE_DEPTH + 1);
    localparam int WORD_W = BODY_W + TIME_BITS;

    // config
    logic [DELAY_W-1:0] r_min_delay;
    logic [DELAY_W-1:0] r_max_delay;
    logic [BC_W-1:0]    r_body_limit;

    // latched item
    logic [OP_W-1:0]      r_op;
    logic                 r_frame_valid;
    logic [CAM_W-1:0]     r_cam;
    logic [BODY_W-1:0]    r_body;
    logic [TIME_BITS-1:0] r_time;

    // table control and counters
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] r_rd_idx;
    logic [FILL_W-1:0] r_wr_idx;
    logic [FILL_W-1:0] r_exp_cnt;
    logic              r_ev_valid;
    logic              r_found;
    logic              r_matched;
    logic              r_dropped;
    logic [CNT_W-1:0]  r_kept;
    logic [CNT_W-1:0]  r_removed;

    // result register
    logic                r_out_valid;
    logic [NARROW_W-1:0] r_out_pending;
    logic [CNT_W-1:0]    r_out_kept;
    logic [CNT_W-1:0]    r_out_removed;
    logic                r_out_matched;
    logic [NARROW_W-1:0] r_out_expired;
    logic                r_out_dropped;

    logic                 body_ok;
    logic                 front_ok;
    logic                 zone_ok;
    logic                 rear_ok;
    logic                 table_full;
    logic                 rd_more;
    logic [WORD_W-1:0]    rd_data;
    logic [TIME_BITS-1:0] ent_time;
    logic [BODY_W-1:0]    ent_body;
    logic [TIME_BITS-1:0] age;
    logic [TIME_BITS-1:0] min_ext;
    logic [TIME_BITS-1:0] max_ext;
    logic                 not_future;
    logic                 is_expired;
    logic                 is_match;
    logic                 drop;
    logic                 do_append;
    logic                 scan_keep;
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [WORD_W-1:0]    ram_wdata;

    dmwt_ram #(
        .WIDTH(WORD_W),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(r_rd_idx[IDX_W-1:0]),
        .o_rdata(rd_data)
    );

    // item decode
    assign body_ok    = {1'b0, r_body} < r_body_limit;
    assign front_ok   = r_frame_valid && (r_cam < FRONT_CAM_LIMIT) && body_ok;
    assign zone_ok    = ((r_cam == REAR_LEFT_CAM) && (r_body < ZONE_SPLIT)) ||
                        ((r_cam == REAR_RIGHT_CAM) && (r_body >= ZONE_SPLIT));
    assign rear_ok    = r_frame_valid && zone_ok && body_ok;
    assign table_full = r_fill >= FILL_W'(TABLE_DEPTH);
    assign rd_more    = r_rd_idx < r_fill;

    // entry evaluation on the registered read word
    assign ent_time   = rd_data[TIME_BITS-1:0];
    assign ent_body   = rd_data[TIME_BITS +: BODY_W];
    assign min_ext    = TIME_BITS'(r_min_delay);
    assign max_ext    = TIME_BITS'(r_max_delay);
    assign not_future = r_time >= ent_time;
    assign age        = r_time - ent_time;
    assign is_expired = not_future && (age > max_ext);
    assign is_match   = (ent_body == r_body) && not_future &&
                        (age >= min_ext) && (age <= max_ext);
    assign drop       = (r_op == OP_TICK) ? is_expired : (!r_found && is_match);

    // appended entries go to the fill index; kept entries are copied down to the write pointer
    assign do_append = i_cmd.apply && (r_op == OP_FRONT) && front_ok && !table_full;
    assign scan_keep = i_cmd.scan_step && r_ev_valid && !drop;
    assign ram_we    = do_append || scan_keep;
    assign ram_waddr = do_append ? r_fill[IDX_W-1:0] : r_wr_idx[IDX_W-1:0];
    assign ram_wdata = do_append ? {r_body, r_time} : rd_data;

    assign o_status.need_scan = ((r_op == OP_REAR) && rear_ok) || (r_op == OP_TICK);
    assign o_status.scan_done = !rd_more && !r_ev_valid;
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_delay  <= RST_MIN_DELAY;
            r_max_delay  <= RST_MAX_DELAY;
            r_body_limit <= RST_BODY_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_MIN_DELAY:  r_min_delay  <= i_cfg_wdata;
                REG_MAX_DELAY:  r_max_delay  <= i_cfg_wdata;
                REG_BODY_LIMIT: r_body_limit <= i_cfg_wdata[BC_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op          <= i_operation;
            r_frame_valid <= i_frame_valid;
            r_cam         <= i_camera;
            r_body        <= i_body;
            r_time        <= i_time_ms;
        end
        if (i_cmd.publish) begin
            r_out_pending <= NARROW_W'(r_fill);
            r_out_kept    <= r_kept;
            r_out_removed <= r_removed;
            r_out_matched <= r_matched;
            r_out_expired <= NARROW_W'(r_exp_cnt);
            r_out_dropped <= r_dropped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_rd_idx    <= '0;
            r_wr_idx    <= '0;
            r_exp_cnt   <= '0;
            r_ev_valid  <= 1'b0;
            r_found     <= 1'b0;
            r_matched   <= 1'b0;
            r_dropped   <= 1'b0;
            r_kept      <= '0;
            r_removed   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_matched <= 1'b0;
                r_dropped <= 1'b0;
                r_exp_cnt <= '0;
            end
            if (i_cmd.apply) begin
                case (r_op)
                    OP_FRONT: begin
                        if (front_ok) begin
                            if (table_full) begin
                                r_dropped <= 1'b1;
                            end else begin
                                r_fill <= r_fill + FILL_W'(1);
                            end
                        end
                    end
                    OP_CLEAR: begin
                        r_fill    <= '0;
                        r_kept    <= '0;
                        r_removed <= '0;
                    end
                    default: ;
                endcase
            end
            if (i_cmd.scan_init) begin
                r_rd_idx   <= '0;
                r_wr_idx   <= '0;
                r_ev_valid <= 1'b0;
                r_found    <= 1'b0;
            end
            if (i_cmd.scan_step) begin
                if (rd_more) begin
                    r_rd_idx <= r_rd_idx + FILL_W'(1);
                end
                r_ev_valid <= rd_more;
                if (r_ev_valid) begin
                    if (drop) begin
                        if (r_op == OP_TICK) begin
                            r_exp_cnt <= r_exp_cnt + FILL_W'(1);
                            r_removed <= sat_inc(r_removed);
                        end else begin
                            r_found   <= 1'b1;
                            r_matched <= 1'b1;
                            r_kept    <= sat_inc(r_kept);
                        end
                    end else begin
                        r_wr_idx <= r_wr_idx + FILL_W'(1);
                    end
                end
            end
            if (i_cmd.scan_end) begin
                r_fill <= r_wr_idx;
            end
            if (i_cmd.publish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_pending_count = r_out_pending;
    assign o_kept_total    = r_out_kept;
    assign o_removed_total = r_out_removed;
    assign o_matched       = r_out_matched;
    assign o_expired_now   = r_out_expired;
    assign o_dropped       = r_out_dropped;

    `DMWT_ASSERT_ALWAYS(a_fill_bound, i_clk, i_rst_n, r_fill <= FILL_W'(TABLE_DEPTH), "fill above depth")
    `DMWT_ASSERT_IMPLY(a_wr_behind_rd, i_clk, i_rst_n, i_cmd.scan_step && r_ev_valid, r_wr_idx < r_rd_idx, "compaction write overtook read")
    `DMWT_ASSERT_IMPLY(a_match_only_rear, i_clk, i_rst_n, r_matched, (r_op == OP_REAR) && (r_exp_cnt == '0), "match flagged outside rear scan")
    `DMWT_ASSERT_NEXT(a_publish_valid, i_clk, i_rst_n, i_cmd.publish, r_out_valid, "published result not valid")

endmodule

### design/delayed_match_window_tracker.sv
// top level of the delayed match window tracker
// path: front, clear and ignored requests go from idle through the execute and done states
// path: valid rear and all tick requests add a scan over every pending entry before the done state
// throughput: one request at a time; the next is taken in the cycle after the result is loaded
// the compaction scan over the table memory sets the rate of rear and tick requests
// reset: synchronous active-low; empties the table, zeroes counters, restores register defaults
module delayed_match_window_tracker import dmwt_pkg::*; #(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int TIME_BITS   = DEF_TIME_BITS
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // slave side: one request per handshake
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // camera [2:0], body [5:3], time_ms [6 +: TIME_BITS], zero pad
    input  logic [((CAM_W+BODY_W+TIME_BITS+7)/8)*8-1:0] s_axis_tdata,
    // operation [1:0], frame_valid [2]
    input  logic [IN_USER_W-1:0]                    s_axis_tuser,
    // master side: one result per request
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // pending_count [5:0], kept_total [37:6], removed_total [69:38], matched [70],
    // expired_now [76:71], dropped [77], zero pad
    output logic [OUT_DATA_W-1:0]                   m_axis_tdata,
    // configuration write port
    input  logic                                    i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]                   i_cfg_addr,
    input  logic [DELAY_W-1:0]                      i_cfg_wdata
);

    t_cmd    cmd;
    t_status status;

    // unpacked request fields
    logic [OP_W-1:0]      operation;
    logic                 frame_valid;
    logic [CAM_W-1:0]     camera;
    logic [BODY_W-1:0]    body;
    logic [TIME_BITS-1:0] time_ms;

    // result fields
    logic [NARROW_W-1:0] pending_count;
    logic [CNT_W-1:0]    kept_total;
    logic [CNT_W-1:0]    removed_total;
    logic                matched;
    logic [NARROW_W-1:0] expired_now;
    logic                dropped;

    assign operation   = s_axis_tuser[OP_W-1:0];
    assign frame_valid = s_axis_tuser[OP_W];
    assign camera      = s_axis_tdata[CAM_W-1:0];
    assign body        = s_axis_tdata[CAM_W +: BODY_W];
    assign time_ms     = s_axis_tdata[CAM_W+BODY_W +: TIME_BITS];

    // controller: accept, run the table operation, hand over the result
    dmwt_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(s_axis_tvalid),
        .o_in_ready(s_axis_tready),
        .i_status  (status),
        .o_cmd     (cmd)
    );

    // datapath: table memory, compaction pointers, counters, result register
    dmwt_datapath #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .TIME_BITS  (TIME_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_operation    (operation),
        .i_frame_valid  (frame_valid),
        .i_camera       (camera),
        .i_body         (body),
        .i_time_ms      (time_ms),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_pending_count(pending_count),
        .o_kept_total   (kept_total),
        .o_removed_total(removed_total),
        .o_matched      (matched),
        .o_expired_now  (expired_now),
        .o_dropped      (dropped)
    );

    // pack result, lowest field first, zero pad on top
    assign m_axis_tdata = OUT_DATA_W'({dropped, expired_now, matched,
                                       removed_total, kept_total, pending_count});

endmodule
